// File: rtl/btpm_pkg.sv
// Shared types and constants for the binary trie policy pair matcher.
`timescale 1ns / 1ps

package btpm_pkg;

    localparam int ADDR_W  = 32;
    localparam int LEVEL_W = 6;
    localparam int POL_W   = 6;

    // Deepest trie level an address walk can reach.
    localparam logic [LEVEL_W-1:0] MAX_LEVEL = LEVEL_W'(ADDR_W);

    typedef enum logic [1:0] {
        OP_ENABLE  = 2'd0,
        OP_DISABLE = 2'd1,
        OP_ADD     = 2'd2,
        OP_CHECK   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_ZERO,
        ST_RESP
    } state_t;

endpackage

// File: rtl/binary_trie_policy_pair_match.sv
// Top level: binary trie of IPv4 prefixes with policy bitmaps and pair check.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+---------------------------------------
//   in      | input     | in_valid / in_ready  | operation, policy_id, addr_a, addr_b,
//           |           |                      | prefix_len
//   out     | output    | out_valid / out_ready| forward, status
//
// One transaction at a time; in_ready is high only while the block is idle.
// Enable and disable go straight to the response. A check walks the trie from the root
// for each address in turn, down to the depth Dx reached by that address walk
// (at most 32); an add walks down the Ne levels found and links and zeroes the Nn nodes made.
// Each level is read from the registered-read node memory in READ and used in EVAL.
// Reset leaves nodes 0 and 1 in use; the root reads as empty until first written.
`timescale 1ns / 1ps

module binary_trie_policy_pair_match #(
    parameter int NODES    = 4096,
    parameter int POLICIES = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  operation,
    input  logic [5:0]  policy_id,
    input  logic [31:0] addr_a,
    input  logic [31:0] addr_b,
    input  logic [5:0]  prefix_len,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        forward,
    output logic        status
);

    localparam int IW = $clog2(NODES);
    localparam int CW = IW + 1;
    localparam int EW = 2 * IW + POLICIES;
    localparam int C0_LO = POLICIES;
    localparam int C1_LO = POLICIES + IW;

    btpm_pkg::state_t state_reg, state_next;
    btpm_pkg::op_t    op_reg, op_next;

    logic [btpm_pkg::POL_W-1:0]   pol_reg, pol_next;
    logic [btpm_pkg::ADDR_W-1:0]  addr_sh_reg, addr_sh_next;
    logic [btpm_pkg::ADDR_W-1:0]  addr_b_reg, addr_b_next;
    logic [btpm_pkg::LEVEL_W-1:0] len_reg, len_next;
    logic [btpm_pkg::LEVEL_W-1:0] level_reg, level_next;
    logic [IW-1:0]                node_reg, node_next;
    logic [IW-1:0]                new_node_reg, new_node_next;
    logic [POLICIES-1:0]          acc_reg, acc_next;
    logic [POLICIES-1:0]          acc_a_reg, acc_a_next;
    logic                         side_reg, side_next;
    logic [CW-1:0]                nodes_used_reg, nodes_used_next;
    logic [POLICIES-1:0]          policy_enabled_reg, policy_enabled_next;
    logic                         root_init_reg, root_init_next;
    logic                         forward_reg, forward_next;
    logic                         status_reg, status_next;

    logic          ram_wr_en;
    logic [IW-1:0] ram_wr_addr;
    logic [EW-1:0] ram_wr_data;
    logic          ram_rd_en;
    logic [EW-1:0] ram_rd_data;

    logic [EW-1:0]       entry;
    logic [EW-1:0]       entry_upd;
    logic [IW-1:0]       child_sel;
    logic [POLICIES-1:0] acc_new;
    logic [POLICIES-1:0] pol_mask;
    logic                pol_ok;
    logic                store_full;
    logic                in_fire;
    logic                out_fire;

    btpm_node_ram #(
        .DEPTH (NODES),
        .WIDTH (EW)
    ) u_node_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (node_reg),
        .rd_data (ram_rd_data)
    );

    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid && out_ready;

    // The root is never zeroed in memory, so it reads as empty until first written.
    assign entry = (node_reg == IW'(1) && !root_init_reg) ? '0 : ram_rd_data;
    assign child_sel = addr_sh_reg[btpm_pkg::ADDR_W-1] ? entry[C1_LO +: IW]
                                                        : entry[C0_LO +: IW];
    assign acc_new    = acc_reg | entry[POLICIES-1:0];
    assign pol_mask   = POLICIES'(1) << pol_reg;
    assign pol_ok     = {1'b0, policy_id} < 7'(POLICIES);
    assign store_full = nodes_used_reg >= CW'(NODES);

    always_comb
    begin
        entry_upd = entry;
        if (addr_sh_reg[btpm_pkg::ADDR_W-1])
        begin
            entry_upd[C1_LO +: IW] = nodes_used_reg[IW-1:0];
        end
        else
        begin
            entry_upd[C0_LO +: IW] = nodes_used_reg[IW-1:0];
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            btpm_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    if ((btpm_pkg::op_t'(operation) == btpm_pkg::OP_CHECK) ||
                        (btpm_pkg::op_t'(operation) == btpm_pkg::OP_ADD && pol_ok))
                    begin
                        state_next = btpm_pkg::ST_READ;
                    end
                    else
                    begin
                        state_next = btpm_pkg::ST_RESP;
                    end
                end
            end
            btpm_pkg::ST_READ:
            begin
                state_next = btpm_pkg::ST_EVAL;
            end
            btpm_pkg::ST_EVAL:
            begin
                if (op_reg == btpm_pkg::OP_CHECK)
                begin
                    if (level_reg != btpm_pkg::MAX_LEVEL && child_sel != '0)
                    begin
                        state_next = btpm_pkg::ST_READ;
                    end
                    else if (!side_reg)
                    begin
                        state_next = btpm_pkg::ST_READ;
                    end
                    else
                    begin
                        state_next = btpm_pkg::ST_RESP;
                    end
                end
                else
                begin
                    if (level_reg == len_reg)
                    begin
                        state_next = btpm_pkg::ST_RESP;
                    end
                    else if (child_sel != '0)
                    begin
                        state_next = btpm_pkg::ST_READ;
                    end
                    else if (store_full)
                    begin
                        state_next = btpm_pkg::ST_RESP;
                    end
                    else
                    begin
                        state_next = btpm_pkg::ST_ZERO;
                    end
                end
            end
            btpm_pkg::ST_ZERO:
            begin
                state_next = btpm_pkg::ST_READ;
            end
            btpm_pkg::ST_RESP:
            begin
                if (out_fire)
                begin
                    state_next = btpm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = btpm_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb
    begin
        in_ready  = (state_reg == btpm_pkg::ST_IDLE);
        out_valid = (state_reg == btpm_pkg::ST_RESP);
        ram_rd_en = (state_reg == btpm_pkg::ST_READ);
        forward   = forward_reg;
        status    = status_reg;
    end

    // Datapath and node memory writes.
    always_comb
    begin
        op_next             = op_reg;
        pol_next            = pol_reg;
        addr_sh_next        = addr_sh_reg;
        addr_b_next         = addr_b_reg;
        len_next            = len_reg;
        level_next          = level_reg;
        node_next           = node_reg;
        new_node_next       = new_node_reg;
        acc_next            = acc_reg;
        acc_a_next          = acc_a_reg;
        side_next           = side_reg;
        nodes_used_next     = nodes_used_reg;
        policy_enabled_next = policy_enabled_reg;
        root_init_next      = root_init_reg;
        forward_next        = forward_reg;
        status_next         = status_reg;
        ram_wr_en           = 1'b0;
        ram_wr_addr         = node_reg;
        ram_wr_data         = entry_upd;

        case (state_reg)
            btpm_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    op_next      = btpm_pkg::op_t'(operation);
                    pol_next     = policy_id;
                    addr_sh_next = addr_a;
                    addr_b_next  = addr_b;
                    len_next     = (prefix_len > btpm_pkg::MAX_LEVEL) ? btpm_pkg::MAX_LEVEL
                                                                      : prefix_len;
                    level_next   = '0;
                    node_next    = IW'(1);
                    acc_next     = '0;
                    side_next    = 1'b0;
                    forward_next = 1'b0;
                    status_next  = 1'b0;
                    if (pol_ok)
                    begin
                        if (btpm_pkg::op_t'(operation) == btpm_pkg::OP_ENABLE)
                        begin
                            policy_enabled_next = policy_enabled_reg |
                                                  (POLICIES'(1) << policy_id);
                        end
                        else if (btpm_pkg::op_t'(operation) == btpm_pkg::OP_DISABLE)
                        begin
                            policy_enabled_next = policy_enabled_reg &
                                                  ~(POLICIES'(1) << policy_id);
                        end
                    end
                end
            end
            btpm_pkg::ST_EVAL:
            begin
                if (op_reg == btpm_pkg::OP_CHECK)
                begin
                    if (level_reg != btpm_pkg::MAX_LEVEL && child_sel != '0)
                    begin
                        acc_next     = acc_new;
                        node_next    = child_sel;
                        level_next   = level_reg + 1'b1;
                        addr_sh_next = addr_sh_reg << 1;
                    end
                    else if (!side_reg)
                    begin
                        // First path done: restart from the root with the second address.
                        acc_a_next   = acc_new;
                        acc_next     = '0;
                        side_next    = 1'b1;
                        node_next    = IW'(1);
                        level_next   = '0;
                        addr_sh_next = addr_b_reg;
                    end
                    else
                    begin
                        forward_next = |(acc_a_reg & acc_new & policy_enabled_reg);
                    end
                end
                else
                begin
                    if (level_reg == len_reg)
                    begin
                        ram_wr_en   = 1'b1;
                        ram_wr_data = {entry[EW-1:POLICIES], entry[POLICIES-1:0] | pol_mask};
                        if (node_reg == IW'(1))
                        begin
                            root_init_next = 1'b1;
                        end
                    end
                    else if (child_sel != '0)
                    begin
                        node_next    = child_sel;
                        level_next   = level_reg + 1'b1;
                        addr_sh_next = addr_sh_reg << 1;
                    end
                    else if (store_full)
                    begin
                        status_next = 1'b1;
                    end
                    else
                    begin
                        // Link the new node into its parent; it is zeroed next cycle.
                        ram_wr_en       = 1'b1;
                        new_node_next   = nodes_used_reg[IW-1:0];
                        nodes_used_next = nodes_used_reg + 1'b1;
                        if (node_reg == IW'(1))
                        begin
                            root_init_next = 1'b1;
                        end
                    end
                end
            end
            btpm_pkg::ST_ZERO:
            begin
                ram_wr_en    = 1'b1;
                ram_wr_addr  = new_node_reg;
                ram_wr_data  = '0;
                node_next    = new_node_reg;
                level_next   = level_reg + 1'b1;
                addr_sh_next = addr_sh_reg << 1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= btpm_pkg::ST_IDLE;
            nodes_used_reg     <= CW'(2);
            policy_enabled_reg <= '0;
            root_init_reg      <= 1'b0;
            forward_reg        <= 1'b0;
            status_reg         <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            nodes_used_reg     <= nodes_used_next;
            policy_enabled_reg <= policy_enabled_next;
            root_init_reg      <= root_init_next;
            forward_reg        <= forward_next;
            status_reg         <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        pol_reg      <= pol_next;
        addr_sh_reg  <= addr_sh_next;
        addr_b_reg   <= addr_b_next;
        len_reg      <= len_next;
        level_reg    <= level_next;
        node_reg     <= node_next;
        new_node_reg <= new_node_next;
        acc_reg      <= acc_next;
        acc_a_reg    <= acc_a_next;
        side_reg     <= side_next;
    end

endmodule

// File: rtl/btpm_node_ram.sv
// Node store: one write port and one registered read port.
`timescale 1ns / 1ps

module btpm_node_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 88
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
